### rtl/pcrd_pkg.sv
// ----------------------------------------------------------------------------
// pcrd_pkg: shared types and constants of the per-ID command rate detector
// Word formats, register map, action codes and the control group that the
// sequencer hands to the row of entry cells.
// ----------------------------------------------------------------------------
package pcrd_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam logic [15:0] LIFETIME_RST = 16'd20000;
    localparam logic [5:0]  LIMIT_RST    = 6'd10;

    // Register map, indexed by paddr[3:2].
    localparam int          PADDR_W   = 4;
    localparam logic [1:0]  REG_TRACK = 2'd0;
    localparam logic [1:0]  REG_LIFE  = 2'd1;
    localparam logic [1:0]  REG_LIMIT = 2'd2;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] unit_id;
        logic [21:0] elapsed_ms;
        logic        final_unit;
    } t_in_word;

    typedef struct packed {
        logic       thrash_detected;
        logic [6:0] prior_count;
        logic       store_overflow;
        logic       command_done;
    } t_out_word;

    typedef struct packed {
        logic shift;   // every cell takes its younger neighbor's entry
        logic append;  // the tail cell takes the new entry
    } t_chain_ctl;

endpackage

### rtl/per_id_command_rate_detector.sv
// ----------------------------------------------------------------------------
// per_id_command_rate_detector: sliding-window command rate detector
// Keeps recent commands in a row of cells, expires them on time ticks and
// flags a unit identifier that reaches the configured command count.
//
//   Channel   Direction  Handshake                      Payload
//   input     in         i_in_valid / o_in_ready        i_in_word (t_in_word)
//   output    out        o_out_valid / i_out_ready      o_out_word (t_out_word)
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A tracked command waits while the match count ripples through the whole
// row of cells, one cell per cycle. A tick expires entries as the row drops
// one entry per cycle. An untracked command skips the scan. One word is
// worked on at a time; a new word is taken while the previous result still
// waits in the output register.
// Reset is synchronous and empties the store and clears the time.
// ----------------------------------------------------------------------------
module per_id_command_rate_detector #(
    parameter int STORE_DEPTH = pcrd_pkg::STORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pcrd_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pcrd_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pcrd_pkg::*;

    localparam int OCC_W  = $clog2(STORE_DEPTH + 1);
    localparam int SCAN_W = $clog2(STORE_DEPTH);
    localparam int CMP_W  = (OCC_W + 1 > 6) ? OCC_W + 1 : 6;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPIRE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        r_state;
    logic [SCAN_W-1:0] r_scan;
    logic [OCC_W-1:0]  r_occ;
    logic [31:0]       r_time;
    logic [31:0]       r_unit;
    logic              r_final;
    t_out_word         r_res;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              r_track;
    logic [15:0]       r_life;
    logic [5:0]        r_limit;

    t_chain_ctl        w_ctl;
    logic [31:0]       w_head_stamp;
    logic [OCC_W-1:0]  w_total;
    logic              w_expired;
    logic              w_thrash;
    logic              w_overflow;
    logic [OCC_W-1:0]  w_eff_occ;
    logic [31:0]       w_new_stamp;
    logic              w_in_acc;
    logic              w_cfg_wr;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 1'b0;
            r_life  <= LIFETIME_RST;
            r_limit <= LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_TRACK: r_track <= pwdata[0];
                REG_LIFE:  r_life  <= pwdata[15:0];
                REG_LIMIT: r_limit <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TRACK: prdata = {31'b0, r_track};
            REG_LIFE:  prdata = {16'b0, r_life};
            REG_LIMIT: prdata = {26'b0, r_limit};
            default:   prdata = '0;
        endcase
    end

    // ---------------- datapath decisions ----------------
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_expired = (r_occ != '0) && ((w_head_stamp + {16'b0, r_life}) < r_time);

    // The count is taken before the clear; a thrash empties the store first.
    assign w_thrash    = (CMP_W'(w_total) + CMP_W'(1)) == CMP_W'(r_limit);
    assign w_eff_occ   = w_thrash ? '0 : r_occ;
    assign w_overflow  = (w_eff_occ == OCC_W'(STORE_DEPTH));
    assign w_new_stamp = w_thrash ? 32'd0 : r_time;

    assign w_ctl.shift  = (r_state == ST_EXPIRE) && w_expired;
    assign w_ctl.append = (r_state == ST_APPEND) && !w_overflow;

    pcrd_chain #(
        .STORE_DEPTH (STORE_DEPTH),
        .OCC_W       (OCC_W)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_occ        (r_occ),
        .i_wr_idx     (w_eff_occ),
        .i_new_unit   (r_unit),
        .i_new_stamp  (w_new_stamp),
        .i_key        (r_unit),
        .o_head_stamp (w_head_stamp),
        .o_total      (w_total)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_occ       <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In ST_DONE the output register is refilled, so valid stays up.
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_word.action == ACT_TICK) begin
                            r_time  <= r_time + 32'(i_in_word.elapsed_ms);
                            r_state <= ST_EXPIRE;
                        end else if (r_track) begin
                            r_scan  <= '0;
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_EXPIRE: begin
                    if (w_expired) begin
                        r_occ <= r_occ - OCC_W'(1);
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (r_scan == SCAN_W'(STORE_DEPTH - 1)) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_scan <= r_scan + SCAN_W'(1);
                    end
                end
                ST_APPEND: begin
                    r_time  <= w_new_stamp;
                    r_occ   <= w_overflow ? w_eff_occ : w_eff_occ + OCC_W'(1);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result and word registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_unit  <= i_in_word.unit_id;
            r_final <= i_in_word.final_unit;
            r_res   <= '{thrash_detected: 1'b0, prior_count: 7'd0,
                         store_overflow: 1'b0, command_done: i_in_word.final_unit};
        end else if (r_state == ST_APPEND) begin
            r_res   <= '{thrash_detected: w_thrash, prior_count: 7'(w_total),
                         store_overflow: w_overflow, command_done: r_final};
        end
        if ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------- assertions ----------------
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(STORE_DEPTH))
        else $error("occupancy exceeds the store depth");

    a_tick_expires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.action == ACT_TICK)) |=> (r_state == ST_EXPIRE))
        else $error("tick word did not start expiry");

    a_shift_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |=> (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("expiry shift without matching occupancy drop");

    a_thrash_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.thrash_detected) |-> !o_out_word.store_overflow)
        else $error("thrash and overflow reported together");

endmodule

### rtl/pcrd_cell.sv
// ----------------------------------------------------------------------------
// pcrd_cell: one entry cell of the store
// Holds one identifier and time stamp, shifts toward the oldest end on
// expiry, and adds its own match to the running count passed along the row.
// ----------------------------------------------------------------------------
module pcrd_cell #(
    parameter int CNT_W = 7
) (
    input  logic                  i_clk,
    input  pcrd_pkg::t_chain_ctl  i_ctl,
    input  logic                  i_live,
    input  logic                  i_tail,
    input  logic [31:0]           i_nbr_unit,
    input  logic [31:0]           i_nbr_stamp,
    input  logic [31:0]           i_new_unit,
    input  logic [31:0]           i_new_stamp,
    input  logic [31:0]           i_key,
    input  logic [CNT_W-1:0]      i_cnt,
    output logic [31:0]           o_unit,
    output logic [31:0]           o_stamp,
    output logic [CNT_W-1:0]      o_cnt
);
    import pcrd_pkg::*;

    logic [31:0]      r_unit, n_unit;
    logic [31:0]      r_stamp, n_stamp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_match;

    always_comb begin
        n_unit  = r_unit;
        n_stamp = r_stamp;
        if (i_ctl.shift) begin
            n_unit  = i_nbr_unit;
            n_stamp = i_nbr_stamp;
        end else if (i_ctl.append && i_tail) begin
            n_unit  = i_new_unit;
            n_stamp = i_new_stamp;
        end
    end

    // The count settles one cell further down the row in every cycle.
    assign w_match = i_live && (r_unit == i_key);
    assign n_cnt   = i_cnt + CNT_W'(w_match);

    always_ff @(posedge i_clk) begin
        r_unit  <= n_unit;
        r_stamp <= n_stamp;
        r_cnt   <= n_cnt;
    end

    assign o_unit  = r_unit;
    assign o_stamp = r_stamp;
    assign o_cnt   = r_cnt;

endmodule

### rtl/pcrd_chain.sv
// ----------------------------------------------------------------------------
// pcrd_chain: row of entry cells
// Cell 0 holds the oldest entry. Cells below the occupancy are live; the
// match count ripples from cell 0 to the last cell, one cell per cycle.
// ----------------------------------------------------------------------------
module pcrd_chain #(
    parameter int STORE_DEPTH = pcrd_pkg::STORE_DEPTH_DEF,
    parameter int OCC_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  pcrd_pkg::t_chain_ctl  i_ctl,
    input  logic [OCC_W-1:0]      i_occ,
    input  logic [OCC_W-1:0]      i_wr_idx,
    input  logic [31:0]           i_new_unit,
    input  logic [31:0]           i_new_stamp,
    input  logic [31:0]           i_key,
    output logic [31:0]           o_head_stamp,
    output logic [OCC_W-1:0]      o_total
);
    import pcrd_pkg::*;

    logic [31:0]      w_unit  [STORE_DEPTH];
    logic [31:0]      w_stamp [STORE_DEPTH];
    logic [OCC_W-1:0] w_cnt   [STORE_DEPTH];

    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
        logic [31:0]      w_nbr_unit;
        logic [31:0]      w_nbr_stamp;
        logic [OCC_W-1:0] w_cnt_in;

        if (k == STORE_DEPTH - 1) begin : g_last
            assign w_nbr_unit  = '0;
            assign w_nbr_stamp = '0;
        end else begin : g_mid
            assign w_nbr_unit  = w_unit[k+1];
            assign w_nbr_stamp = w_stamp[k+1];
        end

        if (k == 0) begin : g_first
            assign w_cnt_in = '0;
        end else begin : g_rest
            assign w_cnt_in = w_cnt[k-1];
        end

        pcrd_cell #(
            .CNT_W (OCC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_live      (OCC_W'(k) < i_occ),
            .i_tail      (OCC_W'(k) == i_wr_idx),
            .i_nbr_unit  (w_nbr_unit),
            .i_nbr_stamp (w_nbr_stamp),
            .i_new_unit  (i_new_unit),
            .i_new_stamp (i_new_stamp),
            .i_key       (i_key),
            .i_cnt       (w_cnt_in),
            .o_unit      (w_unit[k]),
            .o_stamp     (w_stamp[k]),
            .o_cnt       (w_cnt[k])
        );
    end

    assign o_head_stamp = w_stamp[0];
    assign o_total      = w_cnt[STORE_DEPTH-1];

endmodule
